// ===== src/ilp_pkg.sv =====
// Package for the integer literal parser: parse phases, status codes,
// character constants and the digit decode type. No dependencies.
package ilp_pkg;

	// Default width of the digit accumulator.
	localparam int VALUE_WIDTH_DEF = 32;

	// Width of the result value and of one character.
	localparam int RESULT_WIDTH = 32;
	localparam int CHAR_WIDTH   = 8;

	// Characters that steer the parse.
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_ONE     = 8'h31;
	localparam logic [7:0] CHAR_SEVEN   = 8'h37;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;

	// Where the parser stands within the current word.
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SIGN  = 3'd1,
		PH_ZERO  = 3'd2,
		PH_DEC   = 3'd3,
		PH_OCT   = 3'd4,
		PH_HEX   = 3'd5
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_DIGIT   = 2'd1,
		ST_NOT_NUMERIC = 2'd2
	} status_t;

	// Number base that a digit is decoded in.
	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	// Decoded digit: ok is low when the character is no digit of the base.
	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} digit_t;

endpackage

// ===== src/ilp_char_if.sv =====
// Character channel of the integer literal parser: one character per transaction.
// Depends on ilp_pkg for the character width.
interface ilp_char_if;
	logic                           valid;
	logic                           ready;
	logic [ilp_pkg::CHAR_WIDTH-1:0] char_code;
	logic                           last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/ilp_result_if.sv =====
// Result channel of the integer literal parser: one parsed word per transaction.
// Depends on ilp_pkg for the result width.
interface ilp_result_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [ilp_pkg::RESULT_WIDTH-1:0] value;
	logic [1:0]                              status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== src/ilp_digit.sv =====
// Digit decoder: maps one character to its digit value in the selected base.
// Depends on ilp_pkg for the base, digit type and character constants.
module ilp_digit (
	input  logic [ilp_pkg::CHAR_WIDTH-1:0] char_code,
	input  ilp_pkg::base_t                 base,
	output ilp_pkg::digit_t                digit
);

	logic       is_dec;
	logic       is_oct;
	logic       is_lower;
	logic       is_upper;
	logic [7:0] off_dec;
	logic [7:0] off_lower;
	logic [7:0] off_upper;

	// Character class compares.
	assign is_dec   = (char_code >= ilp_pkg::CHAR_ZERO) && (char_code <= ilp_pkg::CHAR_NINE);
	assign is_oct   = (char_code >= ilp_pkg::CHAR_ZERO) && (char_code <= ilp_pkg::CHAR_SEVEN);
	assign is_lower = (char_code >= ilp_pkg::CHAR_LOWER_A) &&
	                  (char_code <= ilp_pkg::CHAR_LOWER_F);
	assign is_upper = (char_code >= ilp_pkg::CHAR_UPPER_A) &&
	                  (char_code <= ilp_pkg::CHAR_UPPER_F);

	assign off_dec   = char_code - ilp_pkg::CHAR_ZERO;
	assign off_lower = char_code - ilp_pkg::CHAR_LOWER_A + 8'd10;
	assign off_upper = char_code - ilp_pkg::CHAR_UPPER_A + 8'd10;

	// Select the digit value and its validity for the base.
	always_comb begin
		digit.ok    = 1'b0;
		digit.value = off_dec[3:0];
		case (base)
			ilp_pkg::BASE_DEC: begin
				digit.ok = is_dec;
			end
			ilp_pkg::BASE_OCT: begin
				digit.ok = is_oct;
			end
			ilp_pkg::BASE_HEX: begin
				if (is_dec) begin
					digit.ok = 1'b1;
				end else if (is_lower) begin
					digit.ok    = 1'b1;
					digit.value = off_lower[3:0];
				end else if (is_upper) begin
					digit.ok    = 1'b1;
					digit.value = off_upper[3:0];
				end
			end
			default: begin
				digit.ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/integer_literal_parser.sv =====
// Integer literal parser: decimal, octal and hexadecimal words to signed integers.
// Results pass the input register, then the result register. Throughput: one character per
// cycle unless a word end holds; a new word may start in the cycle after its predecessor.
// Characters that do not end a word keep flowing while a result waits; a word end holds in the
// input register until the result slot frees. Reset clears all valid bits and the word state.
// Depends on ilp_pkg, ilp_char_if, ilp_result_if and ilp_digit.
module integer_literal_parser #(
	parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ilp_char_if.sink       chars,
	ilp_result_if.source   results
);

	localparam int EXT_WIDTH = 64;

	// Input stage registers.
	logic                           valid_s1;
	logic [ilp_pkg::CHAR_WIDTH-1:0] char_s1;
	logic                           last_s1;

	// Per-word state.
	ilp_pkg::phase_t        phase_q, phase_d;
	ilp_pkg::status_t       error_q, error_d;
	logic                   neg_q, neg_d;
	logic [VALUE_WIDTH-1:0] acc_q, acc_d;

	// Result stage registers.
	logic                                    valid_s2;
	logic signed [ilp_pkg::RESULT_WIDTH-1:0] value_s2;
	ilp_pkg::status_t                        status_s2;

	logic                   advance;
	ilp_pkg::base_t         base;
	ilp_pkg::digit_t        digit;
	logic                   feed;
	logic [VALUE_WIDTH-1:0] acc_fed;
	logic [VALUE_WIDTH-1:0] signed_acc;
	logic [EXT_WIDTH-1:0]   ext_acc;

	// The input stage moves on unless it holds a word end and the result slot is blocked.
	assign advance      = valid_s1 && (!last_s1 || !valid_s2 || results.ready);
	assign chars.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// Base of the digit that the current phase would accumulate.
	always_comb begin
		case (phase_q)
			ilp_pkg::PH_ZERO, ilp_pkg::PH_OCT: base = ilp_pkg::BASE_OCT;
			ilp_pkg::PH_HEX:                   base = ilp_pkg::BASE_HEX;
			default:                           base = ilp_pkg::BASE_DEC;
		endcase
	end

	ilp_digit u_digit (
		.char_code (char_s1),
		.base      (base),
		.digit     (digit)
	);

	// Multiply by the base with shifts and add the digit.
	always_comb begin
		case (base)
			ilp_pkg::BASE_OCT: acc_fed = (acc_q << 3) + VALUE_WIDTH'(digit.value);
			ilp_pkg::BASE_HEX: acc_fed = (acc_q << 4) + VALUE_WIDTH'(digit.value);
			default:           acc_fed = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(digit.value);
		endcase
	end

	// Next phase, sign and error for the character in the input stage.
	always_comb begin
		phase_d = phase_q;
		error_d = error_q;
		neg_d   = neg_q;
		feed    = 1'b0;
		if (error_q == ilp_pkg::ST_OK) begin
			case (phase_q)
				ilp_pkg::PH_START: begin
					if (char_s1 == ilp_pkg::CHAR_MINUS) begin
						neg_d   = 1'b1;
						phase_d = ilp_pkg::PH_SIGN;
					end else if (char_s1 == ilp_pkg::CHAR_ZERO) begin
						phase_d = ilp_pkg::PH_ZERO;
					end else if ((char_s1 >= ilp_pkg::CHAR_ONE) &&
					             (char_s1 <= ilp_pkg::CHAR_NINE)) begin
						phase_d = ilp_pkg::PH_DEC;
						feed    = 1'b1;
					end else begin
						error_d = ilp_pkg::ST_NOT_NUMERIC;
					end
				end
				ilp_pkg::PH_SIGN: begin
					if (char_s1 == ilp_pkg::CHAR_ZERO) begin
						phase_d = ilp_pkg::PH_ZERO;
					end else begin
						phase_d = ilp_pkg::PH_DEC;
						feed    = 1'b1;
					end
				end
				ilp_pkg::PH_ZERO: begin
					if (char_s1 == ilp_pkg::CHAR_LOWER_X) begin
						phase_d = ilp_pkg::PH_HEX;
					end else begin
						phase_d = ilp_pkg::PH_OCT;
						feed    = 1'b1;
					end
				end
				ilp_pkg::PH_DEC, ilp_pkg::PH_OCT, ilp_pkg::PH_HEX: begin
					feed = 1'b1;
				end
				default: begin
					error_d = ilp_pkg::ST_BAD_DIGIT;
				end
			endcase
			if (feed && !digit.ok) begin
				error_d = ilp_pkg::ST_BAD_DIGIT;
			end
		end
	end

	assign acc_d = (feed && digit.ok) ? acc_fed : acc_q;

	// Word state register; a word end returns everything to start of word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ilp_pkg::PH_START;
			error_q <= ilp_pkg::ST_OK;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= ilp_pkg::PH_START;
				error_q <= ilp_pkg::ST_OK;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				error_q <= error_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
			end
		end
	end

	// Apply the sign and sign-extend the accumulator to EXT_WIDTH bits.
	assign signed_acc = neg_d ? (VALUE_WIDTH'(0) - acc_d) : acc_d;
	assign ext_acc    = EXT_WIDTH'(signed'(signed_acc));

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_s2 <= error_d;
			if (error_d == ilp_pkg::ST_OK) begin
				value_s2 <= signed'(ext_acc[ilp_pkg::RESULT_WIDTH-1:0]);
			end else begin
				value_s2 <= '0;
			end
		end
	end

	assign results.valid  = valid_s2;
	assign results.value  = value_s2;
	assign results.status = status_s2;

endmodule
